// ===== hw/rtl/raw_pkg.sv =====
`timescale 1ns / 1ps

package raw_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths
    localparam int WIN_W     = 7;
    localparam int AVG_W     = 24;
    localparam int FRAC_BITS = 8;

    localparam logic [WIN_W-1:0] WIN_RESET = 7'd5;

    // Front-to-back job queue
    localparam int QUEUE_DEPTH = 2;

    // APB register map
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_LSB  = 2;
    localparam int REG_IDX_W    = APB_ADDR_W - REG_IDX_LSB;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = '0;

    // Saturation limits of the average
    localparam logic signed [AVG_W-1:0] AVG_MAX = 24'sh7FFFFF;
    localparam logic signed [AVG_W-1:0] AVG_MIN = 24'sh800000;

    typedef enum logic {
        F_IDLE,
        F_UPD
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } t_back_state;

endpackage

// ===== hw/rtl/raw_ram.sv =====
`timescale 1ns / 1ps

module raw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/raw_front.sv =====
`timescale 1ns / 1ps

module raw_front #(
    parameter int MAX_WINDOW  = raw_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = raw_pkg::SAMPLE_BITS_DEF,
    localparam int PTR_W = $clog2(MAX_WINDOW),
    localparam int CNT_W = $clog2(MAX_WINDOW + 1),
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [raw_pkg::WIN_W-1:0]     i_window_size,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_push_valid,
    input  logic                          i_push_ready,
    output logic signed [SUM_W-1:0]       o_push_sum,
    output logic [CNT_W-1:0]              o_push_count
);

    localparam int CMP_W = (raw_pkg::WIN_W > CNT_W) ? raw_pkg::WIN_W : CNT_W;

    raw_pkg::t_front_state r_state, n_state;

    logic signed [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]              r_count;
    logic [PTR_W-1:0]              r_oldest;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [PTR_W-1:0]              r_slot;
    logic                          r_drop;
    logic                          r_add;

    logic [CMP_W-1:0]              w_win;
    logic [CMP_W-1:0]              w_max;
    logic                          w_full;
    logic [PTR_W:0]                w_slot_raw;
    logic [PTR_W-1:0]              w_slot;
    logic [PTR_W-1:0]              w_oldest_inc;
    logic                          w_accept;
    logic                          w_push;
    logic [SAMPLE_BITS-1:0]        w_rdata;
    logic signed [SAMPLE_BITS-1:0] w_old;
    logic signed [SUM_W-1:0]       n_sum;
    logic [CNT_W-1:0]              n_count;

    // Effective window, saturated at the store depth
    assign w_max  = CMP_W'(MAX_WINDOW);
    assign w_win  = (CMP_W'(i_window_size) > w_max) ? w_max : CMP_W'(i_window_size);
    assign w_full = CMP_W'(r_count) >= w_win;

    // Tail slot: oldest + count, modulo the store depth
    assign w_slot_raw = {1'b0, r_oldest} + (PTR_W + 1)'(r_count);
    assign w_slot = (w_slot_raw >= (PTR_W + 1)'(MAX_WINDOW))
                  ? PTR_W'(w_slot_raw - (PTR_W + 1)'(MAX_WINDOW))
                  : w_slot_raw[PTR_W-1:0];
    assign w_oldest_inc = (r_oldest == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_oldest + 1'b1;

    assign w_accept = i_valid && o_ready;
    assign w_push   = o_push_valid && i_push_ready;

    // Oldest entry is read every cycle; data is ready in F_UPD
    raw_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_WINDOW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_push && r_add),
        .i_waddr(r_slot),
        .i_wdata(r_sample),
        .i_raddr(r_oldest),
        .o_rdata(w_rdata)
    );

    assign w_old = signed'(w_rdata);

    always_comb begin
        n_sum = r_sum;
        if (r_drop) begin
            n_sum = n_sum - SUM_W'(w_old);
        end
        if (r_add) begin
            n_sum = n_sum + SUM_W'(r_sample);
        end
        n_count = (r_add && !r_drop) ? CNT_W'(r_count + 1'b1) : r_count;
    end

    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_push_valid = 1'b0;
        case (r_state)
            raw_pkg::F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = raw_pkg::F_UPD;
                end
            end
            raw_pkg::F_UPD: begin
                o_push_valid = 1'b1;
                if (i_push_ready) begin
                    n_state = raw_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = raw_pkg::F_IDLE;
            end
        endcase
    end

    assign o_push_sum   = n_sum;
    assign o_push_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= raw_pkg::F_IDLE;
            r_sum    <= '0;
            r_count  <= '0;
            r_oldest <= '0;
        end else begin
            r_state <= n_state;
            if (w_push) begin
                r_sum   <= n_sum;
                r_count <= n_count;
                if (r_drop) begin
                    r_oldest <= w_oldest_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample;
            r_slot   <= w_slot;
            r_drop   <= w_full && (r_count != '0);
            r_add    <= !(w_full && (r_count == '0));
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_WINDOW))
        else $error("fill count above store depth");

    a_oldest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oldest <= PTR_W'(MAX_WINDOW - 1))
        else $error("oldest pointer outside store");

    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == raw_pkg::F_UPD))
        else $error("accepted sample not followed by update");

endmodule

// ===== hw/rtl/raw_queue.sv =====
`timescale 1ns / 1ps

module raw_queue #(
    parameter int WIDTH = 30,
    parameter int DEPTH = raw_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = r_cnt != CNT_W'(DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// ===== hw/rtl/raw_back.sv =====
`timescale 1ns / 1ps

module raw_back #(
    parameter int MAX_WINDOW  = raw_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = raw_pkg::SAMPLE_BITS_DEF,
    localparam int CNT_W = $clog2(MAX_WINDOW + 1),
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_pop_valid,
    output logic                              o_pop_ready,
    input  logic signed [SUM_W-1:0]           i_sum,
    input  logic [CNT_W-1:0]                  i_count,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [raw_pkg::AVG_W-1:0]  o_average,
    output logic [CNT_W-1:0]                  o_fill_count
);

    localparam int MAG_W  = SUM_W - 1 + raw_pkg::FRAC_BITS;
    localparam int STEP_W = $clog2(MAG_W);
    localparam int EXT_W  = (MAG_W > raw_pkg::AVG_W) ? MAG_W + 1 : raw_pkg::AVG_W + 1;
    localparam logic [EXT_W-1:0] POS_LIM = EXT_W'((1 << (raw_pkg::AVG_W - 1)) - 1);
    localparam logic [EXT_W-1:0] NEG_LIM = EXT_W'(1 << (raw_pkg::AVG_W - 1));

    raw_pkg::t_back_state r_state, n_state;

    logic [MAG_W-1:0]                 r_q;
    logic [CNT_W-1:0]                 r_rem;
    logic [CNT_W-1:0]                 r_div;
    logic [STEP_W-1:0]                r_step;
    logic                             r_neg;
    logic                             r_ovalid;
    logic signed [raw_pkg::AVG_W-1:0] r_avg;
    logic [CNT_W-1:0]                 r_fill;

    logic [SUM_W-1:0]                 w_abs;
    logic [CNT_W:0]                   w_trial;
    logic                             w_ge;
    logic [EXT_W-1:0]                 w_q_ext;
    logic signed [raw_pkg::AVG_W-1:0] w_result;
    logic                             w_load;
    logic                             w_out_free;

    assign w_abs = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);

    // Restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_q[MAG_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    // Sign and saturate the magnitude quotient
    assign w_q_ext = EXT_W'(r_q);
    always_comb begin
        if (!r_neg) begin
            w_result = (w_q_ext > POS_LIM) ? raw_pkg::AVG_MAX
                                           : raw_pkg::AVG_W'(r_q);
        end else begin
            w_result = (w_q_ext > NEG_LIM) ? raw_pkg::AVG_MIN
                                           : raw_pkg::AVG_W'(-w_q_ext);
        end
    end

    assign w_out_free = !r_ovalid || i_ready;

    always_comb begin
        n_state     = r_state;
        o_pop_ready = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            raw_pkg::B_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_state = (i_count == '0) ? raw_pkg::B_DONE : raw_pkg::B_DIV;
                end
            end
            raw_pkg::B_DIV: begin
                if (r_step == STEP_W'(MAG_W - 1)) begin
                    n_state = raw_pkg::B_DONE;
                end
            end
            raw_pkg::B_DONE: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = raw_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = raw_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= raw_pkg::B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop_ready && i_pop_valid) begin
            r_neg  <= i_sum[SUM_W-1];
            r_q    <= {w_abs[SUM_W-2:0], raw_pkg::FRAC_BITS'(0)};
            r_rem  <= '0;
            r_div  <= i_count;
            r_step <= '0;
        end else if (r_state == raw_pkg::B_DIV) begin
            r_q    <= {r_q[MAG_W-2:0], w_ge};
            r_rem  <= w_ge ? CNT_W'(w_trial - {1'b0, r_div}) : w_trial[CNT_W-1:0];
            r_step <= r_step + 1'b1;
        end
        if (w_load) begin
            r_avg  <= w_result;
            r_fill <= r_div;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_average    = r_avg;
    assign o_fill_count = r_fill;

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == raw_pkg::B_DIV) |-> (r_step < STEP_W'(MAG_W)))
        else $error("division step counter overran");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == raw_pkg::B_DIV) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

endmodule

// ===== hw/rtl/running_average_window.sv =====
`timescale 1ns / 1ps
// A job queue sits between the sample path and the bit-serial divider in the
//   back end, so new samples are accepted while a division runs, until the queue
//   is full. Quotient width MAG_W = SAMPLE_BITS + clog2(MAX_WINDOW) + 8.
// Reset (synchronous, active low): sum, fill count and ring pointer cleared,
//   window_size back to 5, no result pending. Sample store is not cleared.

module running_average_window #(
    parameter int MAX_WINDOW  = raw_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = raw_pkg::SAMPLE_BITS_DEF,
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1),
    localparam int IN_W   = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W  = ((raw_pkg::AVG_W + CNT_W + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    // Sample stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [IN_W-1:0]                  s_axis_tdata,   // [sample]

    // Result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [OUT_W-1:0]                 m_axis_tdata,   // [average, fill_count]

    // Register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [raw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [raw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [raw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
    localparam int JOB_W = SUM_W + CNT_W;

    // Register file: window_size only
    logic [raw_pkg::WIN_W-1:0]     r_window_size;
    logic [raw_pkg::REG_IDX_W-1:0] w_reg_idx;
    logic                          w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[raw_pkg::APB_ADDR_W-1:raw_pkg::REG_IDX_LSB];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign prdata    = (w_reg_idx == raw_pkg::REG_WINDOW_SIZE)
                     ? raw_pkg::APB_DATA_W'(r_window_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= raw_pkg::WIN_RESET;
        end else if (w_cfg_wr && (w_reg_idx == raw_pkg::REG_WINDOW_SIZE)) begin
            r_window_size <= pwdata[raw_pkg::WIN_W-1:0];
        end
    end

    // Front end: ring store, running sum and fill count. Each accepted
    // transaction reads the oldest entry, then in F_UPD updates state and
    // posts a (sum, count) job once the job queue takes it.
    logic                    w_push_valid;
    logic                    w_push_ready;
    logic signed [SUM_W-1:0] w_push_sum;
    logic [CNT_W-1:0]        w_push_count;

    raw_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_window_size(r_window_size),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_sample     (signed'(s_axis_tdata[SAMPLE_BITS-1:0])),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_sum   (w_push_sum),
        .o_push_count (w_push_count)
    );

    // Job queue decouples the sample path from the divider
    logic             w_pop_valid;
    logic             w_pop_ready;
    logic [JOB_W-1:0] w_pop_data;

    raw_queue #(
        .WIDTH(JOB_W),
        .DEPTH(raw_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(w_push_valid),
        .o_push_ready(w_push_ready),
        .i_push_data ({w_push_count, w_push_sum}),
        .o_pop_valid (w_pop_valid),
        .i_pop_ready (w_pop_ready),
        .o_pop_data  (w_pop_data)
    );

    // Back end: sum * 256 / count, truncated toward zero, then saturated
    // to 24 bits. An empty window yields zero without dividing.
    logic signed [raw_pkg::AVG_W-1:0] w_average;
    logic [CNT_W-1:0]                 w_fill_count;

    raw_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_sum       (signed'(w_pop_data[SUM_W-1:0])),
        .i_count     (w_pop_data[JOB_W-1:SUM_W]),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_average   (w_average),
        .o_fill_count(w_fill_count)
    );

    assign m_axis_tdata = OUT_W'({w_fill_count, w_average});

endmodule

// ===== tb/tb_running_average_window.sv =====
`timescale 1ns / 1ps

module tb_running_average_window;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 3;
    localparam int STORE_DEPTH   = raw_pkg::MAX_WINDOW_DEF;
    localparam int SAMPLE_W      = raw_pkg::SAMPLE_BITS_DEF;
    localparam int CNT_W         = $clog2(raw_pkg::MAX_WINDOW_DEF + 1);
    localparam int OUT_W         = ((raw_pkg::AVG_W + CNT_W + 7) / 8) * 8;
    // Index with no register behind it; writes there must be dropped
    localparam logic [raw_pkg::REG_IDX_W-1:0] REG_SPARE = 1'b1;
    // Settling time after the last expected result; pad it
    localparam int DRAIN_CYCLES  = 50;
    localparam int HOLD_CYCLES   = 400;
    localparam int SEGMENTS      = 4;
    localparam int SEG_SAMPLES   = 145;
    localparam int CYCLE_LIMIT   = 600000;

    // One expected result: mean with 8 fractional bits and fill count
    typedef struct packed {
        logic [raw_pkg::AVG_W-1:0] mean;
        logic [CNT_W-1:0]          fill;
    } t_mean_result;

    // Moving-average predictor plus queue of expected results
    class avg_scoreboard;
        logic signed [SAMPLE_W-1:0] ring [STORE_DEPTH];
        longint        total;
        int unsigned   fill;
        int unsigned   oldest;
        int unsigned   window;
        t_mean_result  expected_means [$];
        int            errors;

        function new();
            total  = 0;
            fill   = 0;
            oldest = 0;
            window = raw_pkg::WIN_RESET;
            errors = 0;
        endfunction

        function void set_window(logic [raw_pkg::WIN_W-1:0] value);
            window = value;
        endfunction

        // Accepted sample transaction: update window state, queue the mean
        function void add_sample(logic signed [SAMPLE_W-1:0] smp);
            int unsigned  win;
            longint       mean;
            t_mean_result res;
            win = (window > STORE_DEPTH) ? STORE_DEPTH : window;
            if (fill + 1 > win) begin
                // full (or window shrunk): drop oldest, keep new at tail
                if (fill > 0) begin
                    total -= ring[oldest];
                    oldest = (oldest + 1) % STORE_DEPTH;
                    ring[(oldest + fill - 1) % STORE_DEPTH] = smp;
                    total += smp;
                end
            end else begin
                ring[(oldest + fill) % STORE_DEPTH] = smp;
                total += smp;
                fill++;
            end
            mean = 0;
            if (fill > 0) begin
                mean = (total * 256) / longint'(fill);
                if (mean > longint'(raw_pkg::AVG_MAX))
                    mean = raw_pkg::AVG_MAX;
                if (mean < longint'(raw_pkg::AVG_MIN))
                    mean = raw_pkg::AVG_MIN;
            end
            res.mean = mean[raw_pkg::AVG_W-1:0];
            res.fill = fill[CNT_W-1:0];
            expected_means = {expected_means, res};
        endfunction

        function void check_mean(logic [raw_pkg::AVG_W-1:0] mean,
                                 logic [CNT_W-1:0] fill_seen);
            t_mean_result exp_res;
            if (expected_means.size() == 0) begin
                $error("unexpected result transaction: average %0d, fill_count %0d",
                       $signed(mean), fill_seen);
                errors++;
                return;
            end
            exp_res = expected_means[0];
            expected_means.delete(0);
            if (exp_res.mean !== mean) begin
                $error("average mismatch: expected %0d, actual %0d",
                       $signed(exp_res.mean), $signed(mean));
                errors++;
            end
            if (exp_res.fill !== fill_seen) begin
                $error("fill_count mismatch: expected %0d, actual %0d",
                       exp_res.fill, fill_seen);
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [SAMPLE_W-1:0]              s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [OUT_W-1:0]                 m_axis_tdata;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [raw_pkg::APB_ADDR_W-1:0]   paddr;
    logic [raw_pkg::APB_DATA_W-1:0]   pwdata;
    logic [raw_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;

    avg_scoreboard sb;

    // Idle rates (percent of cycles) for each side
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    // Set by the stimulus to ask the receiver for one long stall
    logic        hold_req;
    int unsigned cycle_count;

    running_average_window DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Watchdog: a hung handshake or a lost result ends here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: tready toggles at the falling edge. A hold request turns into
    // a long stall counted here, while the sender keeps offering samples, so the
    // job queue fills and s_axis_tready drops.
    initial begin
        int unsigned hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req <= 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Result monitor; tdata = {pad, fill_count[30:24], average[23:0]}
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_mean(m_axis_tdata[raw_pkg::AVG_W-1:0],
                          m_axis_tdata[raw_pkg::AVG_W +: CNT_W]);
    end

    // Offer one sample; called and returns at a falling edge. The sample is
    // handed to the predictor at the edge that accepts the transaction.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.add_sample(smp);
        @(negedge i_clk);
    endtask

    // Stop sending, let every expected result come out, then let the pipe settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_means.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup then access; only legal once drained
    task automatic write_reg(input logic [raw_pkg::REG_IDX_W-1:0] idx,
                             input logic [raw_pkg::WIN_W-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {raw_pkg::REG_IDX_LSB{1'b0}}};
        pwdata  <= {{(raw_pkg::APB_DATA_W-raw_pkg::WIN_W){1'b0}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == raw_pkg::REG_WINDOW_SIZE)
            sb.set_window(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly uniform random, with a share of the corner values
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // One idling mode: a few segments, each with its own window setting
    task automatic run_random_mode(input int unsigned send_pct, input int unsigned recv_pct,
                                   input int mode_idx, input bit with_hold);
        logic [raw_pkg::WIN_W-1:0] win_plan [12];
        win_plan = '{7'd3, 7'd0, 7'd9, 7'd1, 7'd20, 7'd2, 7'd33, 7'd50,
                     7'd64, 7'd100, 7'd127, 7'd65};
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (mode_idx == 1 && seg == 3)
                write_reg(raw_pkg::REG_WINDOW_SIZE, 7'($urandom_range(34, 63)));
            else
                write_reg(raw_pkg::REG_WINDOW_SIZE, win_plan[mode_idx * SEGMENTS + seg]);
            if (with_hold && seg == 0)
                hold_req <= 1'b1;
            for (int n = 0; n < SEG_SAMPLES; n++)
                send_sample(pick_sample());
        end
    endtask

    initial begin
        sb            = new();
        cycle_count   = 0;
        hold_req      = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 81;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed part ---
        // window of zero on an empty store: nothing kept, average 0
        write_reg(raw_pkg::REG_WINDOW_SIZE, 7'd0);
        send_sample(16'h04D2);
        send_sample(16'h8000);
        // window of one: average is the single sample
        write_reg(raw_pkg::REG_WINDOW_SIZE, 7'd1);
        send_sample(16'h7FFF);
        // write to an unmapped index must not change the window
        write_reg(REG_SPARE, 7'd64);
        send_sample(16'h8000);
        // back to five: fill, then steady drop of the oldest
        write_reg(raw_pkg::REG_WINDOW_SIZE, raw_pkg::WIN_RESET);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        // shrink while full: count holds, one in one out
        write_reg(raw_pkg::REG_WINDOW_SIZE, 7'd2);
        send_sample(16'h0064);
        send_sample(16'hFF9C);
        // above the store size: saturates to the full store
        write_reg(raw_pkg::REG_WINDOW_SIZE, 7'd127);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0000);

        // --- random part ---
        run_random_mode(19, 81, 0, 1'b0);
        run_random_mode(81, 19, 1, 1'b0);
        run_random_mode(0, 0, 2, 1'b1);

        drain_results();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== running_average_window.f =====
hw/rtl/raw_pkg.sv
hw/rtl/raw_ram.sv
hw/rtl/raw_front.sv
hw/rtl/raw_queue.sv
hw/rtl/raw_back.sv
hw/rtl/running_average_window.sv
tb/tb_running_average_window.sv
